[sv/srs_pkg.sv]
`default_nettype none
package srs_pkg;

    localparam int MAX_RANGES_DEF  = 64;
    localparam int SECTOR_BITS_DEF = 24;

    localparam int REQ_W  = 2;
    localparam int ST_W   = 2;
    localparam int MODE_W = 3;
    localparam int HELD_W = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_ORDER = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // kind of word travelling down the cell chain
    localparam logic [MODE_W-1:0] MODE_INS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SHF = 3'd1;
    localparam logic [MODE_W-1:0] MODE_END = 3'd2;
    localparam logic [MODE_W-1:0] MODE_QRY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DRY = 3'd4;

    typedef struct packed {
        logic       shift_en;
        logic [9:0] lo;
    } t_shift_cmd;

endpackage
`default_nettype wire

[sv/srs_cell.sv]
`default_nettype none
module srs_cell #(
    parameter int IDX         = 0,
    parameter int MAX_RANGES  = srs_pkg::MAX_RANGES_DEF,
    parameter int SECTOR_BITS = srs_pkg::SECTOR_BITS_DEF,
    localparam int CW = $clog2(MAX_RANGES + 1),
    localparam int IW = $clog2(MAX_RANGES)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [CW-1:0]               i_count,
    input  wire logic                        i_shift_en,
    input  wire logic [IW-1:0]               i_shift_lo,
    input  wire logic [SECTOR_BITS-1:0]      i_nb_s,
    input  wire logic [SECTOR_BITS-1:0]      i_nb_e,
    input  wire logic                        i_cv,
    input  wire logic [srs_pkg::MODE_W-1:0]  i_cmode,
    input  wire logic [SECTOR_BITS-1:0]      i_cs,
    input  wire logic [SECTOR_BITS-1:0]      i_ce,
    input  wire logic [CW-1:0]               i_ck,
    input  wire logic [IW-1:0]               i_clo,
    input  wire logic                        i_chit,
    input  wire logic                        i_cin,
    input  wire logic [SECTOR_BITS:0]        i_crun,
    output logic [SECTOR_BITS-1:0]           o_s,
    output logic [SECTOR_BITS-1:0]           o_e,
    output logic                             o_cv,
    output logic [srs_pkg::MODE_W-1:0]       o_cmode,
    output logic [SECTOR_BITS-1:0]           o_cs,
    output logic [SECTOR_BITS-1:0]           o_ce,
    output logic [CW-1:0]                    o_ck,
    output logic [IW-1:0]                    o_clo,
    output logic                             o_chit,
    output logic                             o_cin,
    output logic [SECTOR_BITS:0]             o_crun
);

    logic [SECTOR_BITS-1:0]     r_s, r_e, n_s, n_e;
    logic                       r_cv, n_cv;
    logic [srs_pkg::MODE_W-1:0] r_cmode, n_cmode;
    logic [SECTOR_BITS-1:0]     r_cs, r_ce, n_cs, n_ce;
    logic [CW-1:0]              r_ck, n_ck;
    logic [IW-1:0]              r_clo, n_clo;
    logic                       r_chit, n_chit, r_cin, n_cin;
    logic [SECTOR_BITS:0]       r_crun, n_crun;
    logic                       in_tab, below, above, touch, shift_me;

    assign in_tab   = CW'(IDX) < i_count;
    assign below    = ({1'b0, r_e} + 1'b1) < {1'b0, i_cs};
    assign above    = {1'b0, r_s} > ({1'b0, i_ce} + 1'b1);
    assign touch    = !below && !above;
    assign shift_me = i_shift_en && (IW'(IDX) >= i_shift_lo);

    always_comb begin
        n_s     = r_s;
        n_e     = r_e;
        n_cv    = i_cv;
        n_cmode = i_cmode;
        n_cs    = i_cs;
        n_ce    = i_ce;
        n_ck    = i_ck;
        n_clo   = i_clo;
        n_chit  = i_chit;
        n_cin   = i_cin;
        n_crun  = i_crun;
        if (shift_me) begin
            n_s = i_nb_s;
            n_e = i_nb_e;
        end else if (i_cv) begin
            case (i_cmode)
                srs_pkg::MODE_DRY: begin
                    if (in_tab && touch) n_ck = CW'(1);
                end
                srs_pkg::MODE_INS: begin
                    if (!in_tab) begin
                        n_s     = i_cs;
                        n_e     = i_ce;
                        n_cmode = srs_pkg::MODE_END;
                    end else if (touch) begin
                        n_cs = (r_s < i_cs) ? r_s : i_cs;
                        n_ce = (r_e > i_ce) ? r_e : i_ce;
                        if (i_ck == '0) n_clo = IW'(IDX);
                        n_ck = i_ck + CW'(1);
                    end else if (above) begin
                        n_s     = i_cs;
                        n_e     = i_ce;
                        n_cmode = srs_pkg::MODE_SHF;
                        n_cs    = r_s;
                        n_ce    = r_e;
                    end
                end
                srs_pkg::MODE_SHF: begin
                    n_s = i_cs;
                    n_e = i_ce;
                    if (!in_tab) begin
                        n_cmode = srs_pkg::MODE_END;
                    end else begin
                        n_cs = r_s;
                        n_ce = r_e;
                    end
                end
                srs_pkg::MODE_QRY: begin
                    if (in_tab && !i_chit && r_e >= i_cs) begin
                        n_chit = 1'b1;
                        if (i_cs < r_s) begin
                            n_crun = {1'b0, r_s} - {1'b0, i_cs};
                        end else begin
                            n_cin  = 1'b1;
                            n_crun = {1'b0, r_e} - {1'b0, i_cs} + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_e     <= n_e;
        r_cmode <= n_cmode;
        r_cs    <= n_cs;
        r_ce    <= n_ce;
        r_ck    <= n_ck;
        r_clo   <= n_clo;
        r_chit  <= n_chit;
        r_cin   <= n_cin;
        r_crun  <= n_crun;
    end

    assign o_s     = r_s;
    assign o_e     = r_e;
    assign o_cv    = r_cv;
    assign o_cmode = r_cmode;
    assign o_cs    = r_cs;
    assign o_ce    = r_ce;
    assign o_ck    = r_ck;
    assign o_clo   = r_clo;
    assign o_chit  = r_chit;
    assign o_cin   = r_cin;
    assign o_crun  = r_crun;

endmodule
`default_nettype wire

[sv/sector_range_set.sv]
// Sorted set of disjoint sector ranges held in a chain of MAX_RANGES cells, one range per
// cell. Every request travels down the chain one cell per cycle. An insert makes one
// compaction shift per stored range it absorbs; into a full table it first makes a
// checking pass, and an insert that touches no stored range in that pass is dropped as full.
// A clear, an insert with start after end and an unknown request answer without entering
// the chain. One request is in flight at a time; the result register lets the next request
// be accepted while a result waits.
`default_nettype none
module sector_range_set #(
    parameter int MAX_RANGES  = srs_pkg::MAX_RANGES_DEF,
    parameter int SECTOR_BITS = srs_pkg::SECTOR_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [srs_pkg::REQ_W-1:0]   i_req_type,
    input  wire logic [SECTOR_BITS-1:0]      i_first_sector,
    input  wire logic [SECTOR_BITS-1:0]      i_last_sector,
    input  wire logic [SECTOR_BITS-1:0]      i_query_sector,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [srs_pkg::ST_W-1:0]         o_status,
    output logic                             o_inside_known,
    output logic                             o_none_remaining,
    output logic [SECTOR_BITS:0]             o_run_count,
    output logic [srs_pkg::HELD_W-1:0]       o_ranges_held
);

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int IW = $clog2(MAX_RANGES);
    localparam int SW = 3;

    localparam logic [SW-1:0] S_IDLE  = 3'd0;
    localparam logic [SW-1:0] S_DRY   = 3'd1;
    localparam logic [SW-1:0] S_WAVE  = 3'd2;
    localparam logic [SW-1:0] S_SHIFT = 3'd3;
    localparam logic [SW-1:0] S_DONE  = 3'd4;

    logic                       c_v    [0:MAX_RANGES];
    logic [srs_pkg::MODE_W-1:0] c_mode [0:MAX_RANGES];
    logic [SECTOR_BITS-1:0]     c_s    [0:MAX_RANGES];
    logic [SECTOR_BITS-1:0]     c_e    [0:MAX_RANGES];
    logic [CW-1:0]              c_k    [0:MAX_RANGES];
    logic [IW-1:0]              c_lo   [0:MAX_RANGES];
    logic                       c_hit  [0:MAX_RANGES];
    logic                       c_in   [0:MAX_RANGES];
    logic [SECTOR_BITS:0]       c_run  [0:MAX_RANGES];
    logic [SECTOR_BITS-1:0]     h_s    [0:MAX_RANGES];
    logic [SECTOR_BITS-1:0]     h_e    [0:MAX_RANGES];

    logic [SW-1:0]              r_state;
    logic                       r_inj_v;
    logic [srs_pkg::MODE_W-1:0] r_inj_mode;
    logic [SECTOR_BITS-1:0]     r_inj_s, r_inj_e;
    logic [CW-1:0]              r_count, r_k;
    logic [IW-1:0]              r_lo;
    logic [SECTOR_BITS-1:0]     r_spill_s, r_spill_e;
    logic [srs_pkg::ST_W-1:0]   r_status;
    logic                       r_inside, r_none;
    logic [SECTOR_BITS:0]       r_run;
    logic                       accept, out_free;
    srs_pkg::t_shift_cmd        shift_cmd;

    assign o_stall  = r_state != S_IDLE;
    assign accept   = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    assign shift_cmd.shift_en = r_state == S_SHIFT;
    assign shift_cmd.lo       = 10'(r_lo);

    assign c_v[0]    = r_inj_v;
    assign c_mode[0] = r_inj_mode;
    assign c_s[0]    = r_inj_s;
    assign c_e[0]    = r_inj_e;
    assign c_k[0]    = '0;
    assign c_lo[0]   = '0;
    assign c_hit[0]  = 1'b0;
    assign c_in[0]   = 1'b0;
    assign c_run[0]  = '0;
    assign h_s[MAX_RANGES] = r_spill_s;
    assign h_e[MAX_RANGES] = r_spill_e;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        srs_cell #(
            .IDX         (g),
            .MAX_RANGES  (MAX_RANGES),
            .SECTOR_BITS (SECTOR_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_count    (r_count),
            .i_shift_en (shift_cmd.shift_en),
            .i_shift_lo (IW'(shift_cmd.lo)),
            .i_nb_s     (h_s[g+1]),
            .i_nb_e     (h_e[g+1]),
            .i_cv       (c_v[g]),
            .i_cmode    (c_mode[g]),
            .i_cs       (c_s[g]),
            .i_ce       (c_e[g]),
            .i_ck       (c_k[g]),
            .i_clo      (c_lo[g]),
            .i_chit     (c_hit[g]),
            .i_cin      (c_in[g]),
            .i_crun     (c_run[g]),
            .o_s        (h_s[g]),
            .o_e        (h_e[g]),
            .o_cv       (c_v[g+1]),
            .o_cmode    (c_mode[g+1]),
            .o_cs       (c_s[g+1]),
            .o_ce       (c_e[g+1]),
            .o_ck       (c_k[g+1]),
            .o_clo      (c_lo[g+1]),
            .o_chit     (c_hit[g+1]),
            .o_cin      (c_in[g+1]),
            .o_crun     (c_run[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj_v <= 1'b0;
        end else begin
            r_inj_v <= (accept &&
                        ((i_req_type == srs_pkg::REQ_INSERT &&
                          i_first_sector <= i_last_sector) ||
                         i_req_type == srs_pkg::REQ_QUERY)) ||
                       (r_state == S_DRY && c_v[MAX_RANGES] && c_k[MAX_RANGES] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall && r_state != S_DONE) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status <= srs_pkg::ST_OK;
                        r_inside <= 1'b0;
                        r_none   <= 1'b0;
                        r_run    <= '0;
                        r_state  <= S_DONE;
                        if (i_req_type == srs_pkg::REQ_INSERT) begin
                            r_inj_s    <= i_first_sector;
                            r_inj_e    <= i_last_sector;
                            if (i_first_sector > i_last_sector) begin
                                r_status <= srs_pkg::ST_ORDER;
                            end else if (r_count == CW'(MAX_RANGES)) begin
                                r_inj_mode <= srs_pkg::MODE_DRY;
                                r_state    <= S_DRY;
                            end else begin
                                r_inj_mode <= srs_pkg::MODE_INS;
                                r_state    <= S_WAVE;
                            end
                        end else if (i_req_type == srs_pkg::REQ_QUERY) begin
                            r_inj_mode <= srs_pkg::MODE_QRY;
                            r_inj_s    <= i_query_sector;
                            r_state    <= S_WAVE;
                        end else if (i_req_type == srs_pkg::REQ_CLEAR) begin
                            r_count <= '0;
                        end
                    end
                end
                S_DRY: begin
                    if (c_v[MAX_RANGES]) begin
                        if (c_k[MAX_RANGES] == '0) begin
                            r_status <= srs_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_inj_mode <= srs_pkg::MODE_INS;
                            r_state    <= S_WAVE;
                        end
                    end
                end
                S_WAVE: begin
                    if (c_v[MAX_RANGES]) begin
                        if (c_mode[MAX_RANGES] == srs_pkg::MODE_QRY) begin
                            r_none   <= !c_hit[MAX_RANGES];
                            r_inside <= c_in[MAX_RANGES];
                            r_run    <= c_run[MAX_RANGES];
                            r_state  <= S_DONE;
                        end else begin
                            r_spill_s <= c_s[MAX_RANGES];
                            r_spill_e <= c_e[MAX_RANGES];
                            r_k       <= c_k[MAX_RANGES];
                            r_lo      <= c_lo[MAX_RANGES];
                            r_count   <= r_count + CW'(1) - c_k[MAX_RANGES];
                            r_state   <= (c_k[MAX_RANGES] == '0) ? S_DONE : S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    r_k <= r_k - CW'(1);
                    if (r_k == CW'(1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid          <= 1'b1;
                        o_status         <= r_status;
                        o_inside_known   <= r_inside;
                        o_none_remaining <= r_none;
                        o_run_count      <= r_run;
                        o_ranges_held    <= srs_pkg::HELD_W'(r_count);
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RANGES))
        else $error("range count above table size");

    a_chain_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_v[MAX_RANGES] |-> (r_state == S_DRY || r_state == S_WAVE))
        else $error("chain word arrived outside a wave");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE)
        else $error("accepted word did not start work");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == srs_pkg::ST_FULL) |-> r_count == CW'(MAX_RANGES))
        else $error("full status with room in table");

endmodule
`default_nettype wire

[test/tb_sector_range_set.sv]
`default_nettype none
module tb_sector_range_set;

    localparam int NRANGE = srs_pkg::MAX_RANGES_DEF;
    localparam int SBITS  = srs_pkg::SECTOR_BITS_DEF;
    localparam logic [srs_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [srs_pkg::ST_W-1:0]   status;
        logic                       inside_known;
        logic                       none_remaining;
        logic [SBITS:0]             run_count;
        logic [srs_pkg::HELD_W-1:0] ranges_held;
    } t_answer;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [srs_pkg::REQ_W-1:0]  i_req_type = '0;
    logic [SBITS-1:0]           i_first_sector = '0;
    logic [SBITS-1:0]           i_last_sector = '0;
    logic [SBITS-1:0]           i_query_sector = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b1;
    logic [srs_pkg::ST_W-1:0]   o_status;
    logic                       o_inside_known;
    logic                       o_none_remaining;
    logic [SBITS:0]             o_run_count;
    logic [srs_pkg::HELD_W-1:0] o_ranges_held;

    logic [SBITS-1:0] set_lo [NRANGE];
    logic [SBITS-1:0] set_hi [NRANGE];
    int               set_size;
    t_answer          answer_q [$];
    int               errors = 0;
    int               hold_off = 0;
    int               rx_wait = 0;
    bit               gaps_on = 1'b1;

    sector_range_set u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [1:0] merge_range(logic [SBITS-1:0] s, logic [SBITS-1:0] e);
        int lo, hi, k, after;
        logic [SBITS-1:0] ns, ne;
        logic [SBITS-1:0] ts [NRANGE];
        logic [SBITS-1:0] te [NRANGE];
        lo = 0;
        ns = s;
        ne = e;
        if (s > e) return srs_pkg::ST_ORDER;
        while (lo < set_size && {1'b0, set_hi[lo]} + 1 < {1'b0, s}) lo++;
        hi = lo;
        while (hi < set_size && {1'b0, set_lo[hi]} <= {1'b0, e} + 1) begin
            if (set_lo[hi] < ns) ns = set_lo[hi];
            if (set_hi[hi] > ne) ne = set_hi[hi];
            hi++;
        end
        k = hi - lo;
        if (k == 0 && set_size >= NRANGE) return srs_pkg::ST_FULL;
        after = set_size - hi;
        ts = set_lo;
        te = set_hi;
        for (int j = 0; j < after; j++) begin
            set_lo[lo + 1 + j] = ts[hi + j];
            set_hi[lo + 1 + j] = te[hi + j];
        end
        set_lo[lo] = ns;
        set_hi[lo] = ne;
        set_size = lo + 1 + after;
        return srs_pkg::ST_OK;
    endfunction

    function automatic t_answer serve_request(logic [srs_pkg::REQ_W-1:0] req,
                                              logic [SBITS-1:0] s,
                                              logic [SBITS-1:0] e, logic [SBITS-1:0] q);
        t_answer a;
        int i;
        a = '0;
        if (req == srs_pkg::REQ_INSERT) begin
            a.status = merge_range(s, e);
        end else if (req == srs_pkg::REQ_QUERY) begin
            for (i = 0; i < set_size; i++)
                if (set_hi[i] >= q) break;
            if (i >= set_size) begin
                a.none_remaining = 1'b1;
            end else if (q < set_lo[i]) begin
                a.run_count = {1'b0, set_lo[i]} - {1'b0, q};
            end else begin
                a.inside_known = 1'b1;
                a.run_count = {1'b0, set_hi[i]} - {1'b0, q} + 1'b1;
            end
        end else if (req == srs_pkg::REQ_CLEAR) begin
            set_size = 0;
        end
        a.ranges_held = set_size[srs_pkg::HELD_W-1:0];
        return a;
    endfunction

    task automatic send_word(logic [srs_pkg::REQ_W-1:0] req, logic [SBITS-1:0] s,
                             logic [SBITS-1:0] e, logic [SBITS-1:0] q);
        int gap;
        gap = gaps_on ? $urandom_range(0, 16) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_first_sector <= s;
        i_last_sector <= e;
        i_query_sector <= q;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        answer_q.push_back(serve_request(req, s, e, q));
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_inside_known, o_none_remaining, o_run_count, o_ranges_held};
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = answer_q.pop_front();
                if (got.status != want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.inside_known != want.inside_known)
                    $display("%0t: inside exp %0d got %0d", $time, want.inside_known,
                             got.inside_known);
                if (got.none_remaining != want.none_remaining)
                    $display("%0t: none exp %0d got %0d", $time, want.none_remaining,
                             got.none_remaining);
                if (got.run_count != want.run_count)
                    $display("%0t: run exp %0d got %0d", $time, want.run_count, got.run_count);
                if (got.ranges_held != want.ranges_held)
                    $display("%0t: held exp %0d got %0d", $time, want.ranges_held,
                             got.ranges_held);
                if (got != want) errors++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_stall <= 1'b1;
        end else if (o_valid && rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (o_valid) rx_wait = gaps_on ? $urandom_range(0, 16) : 0;
        end
    end

    function automatic logic [SBITS-1:0] rnd_sector();
        case ($urandom_range(0, 3))
            0: return SBITS'($urandom);
            1: return SBITS'($urandom_range(0, 400));
            2: return '1 - SBITS'($urandom_range(0, 400));
            default: return SBITS'($urandom_range(0, 4000));
        endcase
    endfunction

    task automatic test_directed();
        send_word(srs_pkg::REQ_QUERY, '0, '0, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd10, 24'd5, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd10, 24'd20, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd22, 24'd30, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd21, 24'd21, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd40, 24'd50, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd60, 24'd70, '0);
        send_word(srs_pkg::REQ_INSERT, 24'd5, 24'd65, '0);
        send_word(srs_pkg::REQ_QUERY, '0, '0, 24'd0);
        send_word(srs_pkg::REQ_QUERY, '0, '0, 24'd70);
        send_word(srs_pkg::REQ_QUERY, '0, '0, 24'd71);
        send_word(srs_pkg::REQ_INSERT, '0, '0, '0);
        send_word(srs_pkg::REQ_INSERT, '1, '1, '0);
        send_word(srs_pkg::REQ_INSERT, 24'hFFFFFE, 24'hFFFFFE, '0);
        send_word(srs_pkg::REQ_QUERY, '0, '0, '1);
        send_word(srs_pkg::REQ_QUERY, '0, '0, 24'h800000);
        send_word(REQ_UNKNOWN, '1, '1, '1);
        send_word(srs_pkg::REQ_INSERT, '0, '1, '0);
        send_word(srs_pkg::REQ_QUERY, '0, '0, '0);
        send_word(srs_pkg::REQ_CLEAR, '1, '0, '1);
    endtask

    task automatic test_table_full();
        for (int j = 0; j < NRANGE + 3; j++)
            send_word(srs_pkg::REQ_INSERT, 24'(j * 4), 24'(j * 4 + 1), '0);
        send_word(srs_pkg::REQ_INSERT, 24'd2, 24'd2, '0);
        send_word(srs_pkg::REQ_QUERY, '0, '0, 24'd3);
        send_word(srs_pkg::REQ_INSERT, 24'd1000, 24'd2000, '0);
        send_word(srs_pkg::REQ_CLEAR, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        for (int j = 0; j < 6; j++)
            send_word(srs_pkg::REQ_INSERT, 24'(j * 100), 24'(j * 100 + 7), '0);
    endtask

    task automatic test_random(int n);
        logic [SBITS-1:0] a, b, w;
        int r;
        for (int j = 0; j < n; j++) begin
            gaps_on = (j / 200) % 3 != 2;
            r = $urandom_range(0, 99);
            a = rnd_sector();
            w = $urandom_range(0, 3) == 0 ? SBITS'($urandom) : SBITS'($urandom_range(0, 30));
            b = a + w;
            if (b < a) b = '1;
            if (r < 2) send_word(srs_pkg::REQ_CLEAR, SBITS'($urandom), SBITS'($urandom),
                                 SBITS'($urandom));
            else if (r < 4) send_word(REQ_UNKNOWN, SBITS'($urandom), SBITS'($urandom),
                                      SBITS'($urandom));
            else if (r < 7) send_word(srs_pkg::REQ_INSERT, b, a, SBITS'($urandom));
            else if (r < 55) send_word(srs_pkg::REQ_INSERT, a, b, SBITS'($urandom));
            else send_word(srs_pkg::REQ_QUERY, SBITS'($urandom), SBITS'($urandom),
                           $urandom_range(0, 1) ? rnd_sector() : a);
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        set_size = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(1400);
        i_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire
